[src/rpmt_pkg.sv]
// ----------------------------------------------------------------------------
// rpmt_pkg
// Shared types and constants for the reverse page map table: field widths,
// operation and result codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rpmt_pkg;

   localparam int OP_W       = 2;
   localparam int FRAME_W    = 20;
   localparam int SPACE_W    = 32;
   localparam int PAGE_W     = 52;
   localparam int STATUS_W   = 3;
   localparam int CNT11_W    = 11;
   localparam int CNT32_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 52;

   localparam logic [CNT11_W-1:0] CNT11_MAX = '1;
   localparam logic [CNT32_W-1:0] CNT32_MAX = '1;

   // operation codes (code 3 is unused and ignored)
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VPN_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VPN_HIGH = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      RES_ADDED    = 3'd0,
      RES_IGNORED  = 3'd1,
      RES_DUP      = 3'd2,
      RES_FULL     = 3'd3,
      RES_REMOVED  = 3'd4,
      RES_MISS_INC = 3'd5,
      RES_MISS_BUG = 3'd6,
      RES_QUERY    = 3'd7
   } res_type;

   typedef enum logic [3:0] {
      FSM_INIT,
      FSM_IDLE,
      FSM_HEAD,
      FSM_HEAD_GOT,
      FSM_WALK,
      FSM_CMP,
      FSM_DECIDE,
      FSM_ALLOC,
      FSM_FREE,
      FSM_DONE
   } state_type;

   typedef struct packed {
      logic    sweep;
      logic    take;
      logic    head_rd;
      logic    head_load;
      logic    node_rd;
      logic    step;
      logic    alloc_rd;
      logic    alloc_wr;
      logic    mark_inc;
      logic    unlink;
      logic    free_wr;
      logic    set_status;
      res_type status;
      logic    bug;
      logic    ovf;
      logic    load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic is_query;
      logic is_add;
      logic valid_path;
      logic tracked;
      logic cur_nil;
      logic found;
      logic free_nil;
      logic inc;
      logic rsp_free;
   } sts_type;

endpackage

[src/rpmt_if.sv]
// ----------------------------------------------------------------------------
// rpmt_req_if / rpmt_rsp_if
// Valid/ready channels of the reverse page map table.
// ----------------------------------------------------------------------------
interface rpmt_req_if;
   logic                         valid;
   logic                         ready;
   logic [rpmt_pkg::OP_W-1:0]    op;
   logic [rpmt_pkg::FRAME_W-1:0] frame;
   logic [rpmt_pkg::SPACE_W-1:0] space;
   logic [rpmt_pkg::PAGE_W-1:0]  page;

   modport source(output valid, op, frame, space, page, input ready);
   modport sink(input valid, op, frame, space, page, output ready);
endinterface

interface rpmt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rpmt_pkg::STATUS_W-1:0] status;
   logic [rpmt_pkg::CNT11_W-1:0]  chain_length;
   logic                          mapped;
   logic                          incomplete;
   logic [rpmt_pkg::CNT11_W-1:0]  nodes_used;
   logic [rpmt_pkg::CNT11_W-1:0]  nodes_peak;
   logic [rpmt_pkg::CNT32_W-1:0]  overflows;
   logic [rpmt_pkg::CNT11_W-1:0]  incomplete_frames;
   logic [rpmt_pkg::CNT32_W-1:0]  bugs;

   modport source(output valid, status, chain_length, mapped, incomplete, nodes_used,
                  nodes_peak, overflows, incomplete_frames, bugs, input ready);
   modport sink(input valid, status, chain_length, mapped, incomplete, nodes_used,
                nodes_peak, overflows, incomplete_frames, bugs, output ready);
endinterface

[src/reverse_page_map_table_top.sv]
// ----------------------------------------------------------------------------
// reverse_page_map_table_top
// Reverse map from physical frames to (address space, virtual page) pairs,
// chained per frame through a node pool threaded on a free list.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Payload
// req_chan in   valid/ready   op, frame, space, page
// rsp_chan out  valid/ready   status, chain_length, mapped, incomplete, counters
// csr_*    in   write enable  csr_index, csr_wdata (no read-back)
//
// A tracked item reads its frame's head, then walks the chain node by node,
// stopping early on a matching node for an add or remove, and then updates the
// chain for a successful add or remove; an ignored item, or a query on an
// untracked frame, skips the walk. Each node is read through the single read
// port of the link and node memories, then its key is compared. After reset a
// clearing pass initialises the head and link memories; no item is taken meanwhile.
// A finished result sits in the output register; a stalled rsp_chan holds
// the next result back once it is finished.
// ----------------------------------------------------------------------------
module reverse_page_map_table_top #(
   parameter int FRAMES = 1024,
   parameter int NODES  = 1536
) (
   input  logic                            clock,
   input  logic                            reset,
   rpmt_req_if.sink                        req_chan,
   rpmt_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [rpmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpmt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rpmt_pkg::cmd_type cmd;
   rpmt_pkg::sts_type sts;

   rpmt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   rpmt_datapath #(
      .FRAMES (FRAMES),
      .NODES  (NODES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .in_op                 (req_chan.op),
      .in_frame              (req_chan.frame),
      .in_space              (req_chan.space),
      .in_page               (req_chan.page),
      .cmd                   (cmd),
      .sts                   (sts),
      .out_ready             (rsp_chan.ready),
      .out_valid             (rsp_chan.valid),
      .out_status            (rsp_chan.status),
      .out_chain_length      (rsp_chan.chain_length),
      .out_mapped            (rsp_chan.mapped),
      .out_incomplete        (rsp_chan.incomplete),
      .out_nodes_used        (rsp_chan.nodes_used),
      .out_nodes_peak        (rsp_chan.nodes_peak),
      .out_overflows         (rsp_chan.overflows),
      .out_incomplete_frames (rsp_chan.incomplete_frames),
      .out_bugs              (rsp_chan.bugs)
   );

`ifndef SYNTHESIS
   // no transfer in while the memories are being cleared
   assert property (@(posedge clock) disable iff (reset) cmd.sweep |-> !req_chan.ready)
      else $error("input ready during clearing pass");

   // a node is only taken from a non-empty free list
   assert property (@(posedge clock) disable iff (reset) cmd.alloc_wr |-> !sts.free_nil)
      else $error("allocation from empty free list");

   // a result is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset) cmd.load_rsp |-> sts.rsp_free)
      else $error("result register overwritten");
`endif

endmodule

[src/rpmt_datapath.sv]
// ----------------------------------------------------------------------------
// rpmt_datapath
// Registers, head/link/node memories, free list, counters and the result
// register of the reverse page map table.
// ----------------------------------------------------------------------------
module rpmt_datapath #(
   parameter int FRAMES = 1024,
   parameter int NODES  = 1536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rpmt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpmt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [rpmt_pkg::OP_W-1:0]         in_op,
   input  logic [rpmt_pkg::FRAME_W-1:0]      in_frame,
   input  logic [rpmt_pkg::SPACE_W-1:0]      in_space,
   input  logic [rpmt_pkg::PAGE_W-1:0]       in_page,
   input  rpmt_pkg::cmd_type                 cmd,
   output rpmt_pkg::sts_type                 sts,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [rpmt_pkg::STATUS_W-1:0]     out_status,
   output logic [rpmt_pkg::CNT11_W-1:0]      out_chain_length,
   output logic                              out_mapped,
   output logic                              out_incomplete,
   output logic [rpmt_pkg::CNT11_W-1:0]      out_nodes_used,
   output logic [rpmt_pkg::CNT11_W-1:0]      out_nodes_peak,
   output logic [rpmt_pkg::CNT32_W-1:0]      out_overflows,
   output logic [rpmt_pkg::CNT11_W-1:0]      out_incomplete_frames,
   output logic [rpmt_pkg::CNT32_W-1:0]      out_bugs
);

   localparam int NW   = $clog2(NODES + 1);
   localparam int IW   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int FW   = $clog2(FRAMES);
   localparam int SMAX = (FRAMES > NODES) ? FRAMES : NODES;
   localparam int SW   = $clog2(SMAX);
   localparam int KW   = rpmt_pkg::SPACE_W + rpmt_pkg::PAGE_W;
   localparam logic [NW-1:0] NIL       = '1;
   localparam logic [SW:0]   FRAMES_S  = (SW+1)'(FRAMES);
   localparam logic [SW:0]   NODES_S   = (SW+1)'(NODES);
   localparam logic [SW-1:0] SWEEP_END = SW'(SMAX - 1);
   localparam logic [SW-1:0] LAST_NODE = SW'(NODES - 1);
   localparam logic [rpmt_pkg::FRAME_W:0] FRAMES_F = (rpmt_pkg::FRAME_W+1)'(FRAMES);

   // configuration registers
   logic                          enable_ff;
   logic [rpmt_pkg::CNT11_W-1:0]  fiu_ff;
   logic [rpmt_pkg::PAGE_W-1:0]   vlo_ff;
   logic [rpmt_pkg::PAGE_W-1:0]   vhi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         fiu_ff    <= 11'd1024;
         vlo_ff    <= '0;
         vhi_ff    <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rpmt_pkg::CSR_ENABLE:   enable_ff <= csr_wdata[0];
            rpmt_pkg::CSR_FRAMES:   fiu_ff    <= csr_wdata[rpmt_pkg::CNT11_W-1:0];
            rpmt_pkg::CSR_VPN_LOW:  vlo_ff    <= csr_wdata;
            rpmt_pkg::CSR_VPN_HIGH: vhi_ff    <= csr_wdata;
         endcase
      end
   end

   // item held for the whole walk
   logic [rpmt_pkg::OP_W-1:0]    op_ff;
   logic [rpmt_pkg::FRAME_W-1:0] frame_ff;
   logic [rpmt_pkg::SPACE_W-1:0] space_ff;
   logic [rpmt_pkg::PAGE_W-1:0]  page_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff    <= in_op;
         frame_ff <= in_frame;
         space_ff <= in_space;
         page_ff  <= in_page;
      end
   end

   logic tracked, user, is_query, is_add;
   assign tracked  = enable_ff && (frame_ff != '0)
                     && ({1'b0, frame_ff} < FRAMES_F)
                     && (frame_ff < rpmt_pkg::FRAME_W'(fiu_ff));
   assign user     = (page_ff >= vlo_ff) && (page_ff <= vhi_ff);
   assign is_query = (op_ff == rpmt_pkg::OP_QUERY);
   assign is_add   = (op_ff == rpmt_pkg::OP_ADD);

   // clearing pass counter
   logic [SW-1:0] sweep_ff;
   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else if (cmd.sweep) sweep_ff <= sweep_ff + 1'b1;
   end

   // walk registers
   logic [NW-1:0] cur_ff, prev_ff, hptr_ff, len_ff, free_ff;
   logic          inc_ff;
   logic [NW:0]   head_q;
   logic [NW-1:0] link_q;
   logic [KW-1:0] node_q;
   logic          hit;

   assign hit = (node_q == {space_ff, page_ff});

   always_ff @(posedge clock) begin
      if (cmd.head_load) begin
         cur_ff  <= head_q[NW-1:0];
         hptr_ff <= head_q[NW-1:0];
         inc_ff  <= head_q[NW];
         prev_ff <= NIL;
         len_ff  <= '0;
      end else if (cmd.step) begin
         prev_ff <= cur_ff;
         cur_ff  <= link_q;
         len_ff  <= len_ff + 1'b1;
      end
   end

   // head memory: {incomplete, chain head}
   logic [NW:0]   head_mem [FRAMES];
   logic          head_we;
   logic [FW-1:0] head_waddr;
   logic [NW:0]   head_wdata;

   always_comb begin
      head_we    = 1'b0;
      head_waddr = frame_ff[FW-1:0];
      head_wdata = {inc_ff, hptr_ff};
      priority if (cmd.sweep) begin
         head_we    = ({1'b0, sweep_ff} < FRAMES_S);
         head_waddr = sweep_ff[FW-1:0];
         head_wdata = {1'b0, NIL};
      end else if (cmd.mark_inc) begin
         head_we    = !inc_ff;
         head_wdata = {1'b1, hptr_ff};
      end else if (cmd.alloc_wr) begin
         head_we    = 1'b1;
         head_wdata = {inc_ff, free_ff};
      end else if (cmd.unlink) begin
         head_we    = (prev_ff == NIL);
         head_wdata = {inc_ff, link_q};
      end else begin
         head_we    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      if (cmd.head_rd) head_q <= head_mem[frame_ff[FW-1:0]];
   end

   // link memory
   logic [NW-1:0] link_mem [NODES];
   logic          link_we;
   logic [IW-1:0] link_waddr, link_raddr;
   logic [NW-1:0] link_wdata;

   always_comb begin
      link_we    = 1'b0;
      link_waddr = cur_ff[IW-1:0];
      link_wdata = free_ff;
      priority if (cmd.sweep) begin
         link_we    = ({1'b0, sweep_ff} < NODES_S);
         link_waddr = sweep_ff[IW-1:0];
         link_wdata = (sweep_ff == LAST_NODE) ? NIL : NW'(sweep_ff) + 1'b1;
      end else if (cmd.alloc_wr) begin
         link_we    = 1'b1;
         link_waddr = free_ff[IW-1:0];
         link_wdata = hptr_ff;
      end else if (cmd.unlink) begin
         link_we    = (prev_ff != NIL);
         link_waddr = prev_ff[IW-1:0];
         link_wdata = link_q;
      end else if (cmd.free_wr) begin
         link_we    = 1'b1;
      end else begin
         link_we    = 1'b0;
      end
   end

   assign link_raddr = cmd.alloc_rd ? free_ff[IW-1:0] : cur_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (cmd.node_rd || cmd.alloc_rd) link_q <= link_mem[link_raddr];
   end

   // node key memory: {space, page}
   logic [KW-1:0] node_mem [NODES];
   always_ff @(posedge clock) begin
      if (cmd.alloc_wr) node_mem[free_ff[IW-1:0]] <= {space_ff, page_ff};
      if (cmd.node_rd) node_q <= node_mem[cur_ff[IW-1:0]];
   end

   // free list head and counters
   logic [NW-1:0]                used_ff, peak_ff, used_inc;
   logic [rpmt_pkg::CNT32_W-1:0] ovf_ff, bug_ff;
   logic [rpmt_pkg::CNT11_W-1:0] incf_ff;

   assign used_inc = used_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         used_ff <= '0;
         peak_ff <= '0;
         ovf_ff  <= '0;
         bug_ff  <= '0;
         incf_ff <= '0;
      end else begin
         if (cmd.alloc_wr) begin
            free_ff <= link_q;
            used_ff <= used_inc;
            if (used_inc > peak_ff) peak_ff <= used_inc;
         end else if (cmd.free_wr) begin
            free_ff <= cur_ff;
            if (used_ff != '0) used_ff <= used_ff - 1'b1;
         end
         if (cmd.mark_inc && !inc_ff && incf_ff != rpmt_pkg::CNT11_MAX)
            incf_ff <= incf_ff + 1'b1;
         if (cmd.ovf && ovf_ff != rpmt_pkg::CNT32_MAX) ovf_ff <= ovf_ff + 1'b1;
         if (cmd.bug && bug_ff != rpmt_pkg::CNT32_MAX) bug_ff <= bug_ff + 1'b1;
      end
   end

   // result code
   rpmt_pkg::res_type res_ff;
   always_ff @(posedge clock) begin
      if (cmd.set_status) res_ff <= cmd.status;
   end

   // result register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
      else if (out_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_status            <= res_ff;
         out_chain_length      <= '0;
         out_mapped            <= 1'b0;
         out_incomplete        <= 1'b0;
         if (res_ff == rpmt_pkg::RES_QUERY) begin
            if (tracked) begin
               out_chain_length <= rpmt_pkg::CNT11_W'(len_ff);
               out_mapped       <= (hptr_ff != NIL);
               out_incomplete   <= inc_ff;
            end else begin
               out_incomplete   <= 1'b1;
            end
         end
         out_nodes_used        <= rpmt_pkg::CNT11_W'(used_ff);
         out_nodes_peak        <= rpmt_pkg::CNT11_W'(peak_ff);
         out_overflows         <= ovf_ff;
         out_incomplete_frames <= incf_ff;
         out_bugs              <= bug_ff;
      end
   end

   assign out_valid = rsp_valid_ff;

   // status to controller
   assign sts.sweep_last = (sweep_ff == SWEEP_END);
   assign sts.is_query   = is_query;
   assign sts.is_add     = is_add;
   assign sts.valid_path = tracked && user && (is_add || op_ff == rpmt_pkg::OP_REMOVE);
   assign sts.tracked    = tracked;
   assign sts.cur_nil    = (cur_ff == NIL);
   assign sts.found      = (cur_ff != NIL) && hit;
   assign sts.free_nil   = (free_ff == NIL);
   assign sts.inc        = inc_ff;
   assign sts.rsp_free   = !rsp_valid_ff || out_ready;

endmodule

[src/rpmt_ctrl.sv]
// ----------------------------------------------------------------------------
// rpmt_ctrl
// Controller of the reverse page map table: clearing pass, head read, chain
// walk, update and result hand-off.
// ----------------------------------------------------------------------------
module rpmt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rpmt_pkg::sts_type sts,
   output rpmt_pkg::cmd_type cmd
);

   rpmt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rpmt_pkg::FSM_INIT;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      cmd        = '0;
      cmd.status = rpmt_pkg::RES_IGNORED;
      in_ready   = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         rpmt_pkg::FSM_INIT: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = rpmt_pkg::FSM_IDLE;
         end
         rpmt_pkg::FSM_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.take = 1'b1;
               state_in = rpmt_pkg::FSM_HEAD;
            end
         end
         rpmt_pkg::FSM_HEAD: begin
            if (sts.valid_path || (sts.is_query && sts.tracked)) begin
               cmd.head_rd = 1'b1;
               state_in    = rpmt_pkg::FSM_HEAD_GOT;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = sts.is_query ? rpmt_pkg::RES_QUERY : rpmt_pkg::RES_IGNORED;
               state_in       = rpmt_pkg::FSM_DONE;
            end
         end
         rpmt_pkg::FSM_HEAD_GOT: begin
            cmd.head_load = 1'b1;
            state_in      = rpmt_pkg::FSM_WALK;
         end
         rpmt_pkg::FSM_WALK: begin
            if (sts.cur_nil) begin
               state_in = rpmt_pkg::FSM_DECIDE;
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = rpmt_pkg::FSM_CMP;
            end
         end
         rpmt_pkg::FSM_CMP: begin
            if (!sts.is_query && sts.found) begin
               state_in = rpmt_pkg::FSM_DECIDE;
            end else begin
               cmd.step = 1'b1;
               state_in = rpmt_pkg::FSM_WALK;
            end
         end
         rpmt_pkg::FSM_DECIDE: begin
            state_in = rpmt_pkg::FSM_DONE;
            priority if (sts.is_query) begin
               cmd.set_status = 1'b1;
               cmd.status     = rpmt_pkg::RES_QUERY;
            end else if (sts.is_add) begin
               priority if (sts.found) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rpmt_pkg::RES_DUP;
                  cmd.bug        = 1'b1;
               end else if (sts.free_nil) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rpmt_pkg::RES_FULL;
                  cmd.ovf        = 1'b1;
                  cmd.mark_inc   = 1'b1;
               end else begin
                  cmd.alloc_rd = 1'b1;
                  state_in     = rpmt_pkg::FSM_ALLOC;
               end
            end else begin
               priority if (sts.found) begin
                  cmd.unlink = 1'b1;
                  state_in   = rpmt_pkg::FSM_FREE;
               end else if (sts.inc) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rpmt_pkg::RES_MISS_INC;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rpmt_pkg::RES_MISS_BUG;
                  cmd.bug        = 1'b1;
               end
            end
         end
         rpmt_pkg::FSM_ALLOC: begin
            cmd.alloc_wr   = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = rpmt_pkg::RES_ADDED;
            state_in       = rpmt_pkg::FSM_DONE;
         end
         rpmt_pkg::FSM_FREE: begin
            cmd.free_wr    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = rpmt_pkg::RES_REMOVED;
            state_in       = rpmt_pkg::FSM_DONE;
         end
         rpmt_pkg::FSM_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = rpmt_pkg::FSM_IDLE;
            end
         end
         default: state_in = rpmt_pkg::FSM_INIT;
      endcase
   end

endmodule
